### rtl/jsrl_pkg.sv
// Shared types and constants for the joint setpoint rate limiter.
package jsrl_pkg;

  localparam int POS_W      = 32;
  localparam int JIDX_W     = 4;
  localparam int CMD_W      = 3;
  localparam int STEP_W     = 25;
  localparam int MSQ_W      = 2 * STEP_W;
  localparam int DIFF_W     = POS_W + 1;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SUM_W      = SQ_W + 4;
  localparam int NORM_W     = SUM_W / 2;
  localparam int PROD_W     = POS_W + STEP_W;
  localparam int SQRT_STEPS = NORM_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int ITER_W     = 6;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = STEP_W'(8389);

  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEED       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_LOWER  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_UPPER  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_CLR, OP_MAG, OP_SQ, OP_ACC, OP_CMP,
    OP_SQRT_STEP, OP_PROD, OP_DIV_INIT, OP_DIV_STEP, OP_APPLY
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG1, ST_SQ, ST_ACC, ST_CMP, ST_SQRT,
    ST_MAG2, ST_PROD, ST_DIVLD, ST_DIV, ST_APPLY
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t              op;
    logic [JIDX_W-1:0]   joint;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
    logic limited;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/jsrl_if.sv
// Handshake channel interfaces: input words, result words and configuration.
interface jsrl_in_if;
  import jsrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [JIDX_W-1:0] joint_index;
  logic [POS_W-1:0]  position_value;
  modport source (output valid, command, joint_index, position_value, input ready);
  modport sink   (input valid, command, joint_index, position_value, output ready);
endinterface

interface jsrl_out_if;
  import jsrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [JIDX_W-1:0] joint_number;
  logic [POS_W-1:0]  setpoint;
  logic              speed_limited;
  logic              last_joint;
  modport source (output valid, joint_number, setpoint, speed_limited, last_joint,
                  input ready);
  modport sink   (input valid, joint_number, setpoint, speed_limited, last_joint,
                  output ready);
endinterface

interface jsrl_cfg_if;
  import jsrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/joint_setpoint_rate_limiter.sv
// Top level of the joint setpoint rate limiter.
// Write commands (set target, seed, set limits) are applied as they are taken. A tick
// first forms the sum of squares in one pass over the joints, then, when the step norm
// is within max_step, advances each joint by its raw step; when it is above, it takes
// the bit-serial square root and scales each joint's step with the one-bit-per-cycle
// divider (57 steps). Results leave through an output register; a stalled result
// delays the next joint's update. The input is taken only between items.
module joint_setpoint_rate_limiter import jsrl_pkg::*; #(
  parameter int JOINTS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  jsrl_in_if.sink    in_ch,
  jsrl_out_if.source out_ch,
  jsrl_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  jsrl_ctrl #(.JOINTS(JOINTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  jsrl_dp #(.JOINTS(JOINTS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (in_ch.command),
    .in_joint     (in_ch.joint_index),
    .in_value     (in_ch.position_value),
    .cfg_valid    (cfg_ch.valid),
    .cfg_data     (cfg_ch.data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_joint    (out_ch.joint_number),
    .out_setpoint (out_ch.setpoint),
    .out_limited  (out_ch.speed_limited),
    .out_last     (out_ch.last_joint)
  );

endmodule

### rtl/jsrl_dp.sv
// Datapath: joint tables, sum of squares, bit-serial square root and divider, clamp.
module jsrl_dp import jsrl_pkg::*; #(
  parameter int JOINTS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [JIDX_W-1:0] in_joint,
  input  logic [POS_W-1:0]  in_value,
  input  logic              cfg_valid,
  input  logic [STEP_W-1:0] cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [JIDX_W-1:0] out_joint,
  output logic [POS_W-1:0]  out_setpoint,
  output logic              out_limited,
  output logic              out_last
);

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic [POS_W-1:0]  target_r [JOINTS];
  logic [POS_W-1:0]  setp_r   [JOINTS];
  logic [POS_W-1:0]  lower_r  [JOINTS];
  logic [POS_W-1:0]  upper_r  [JOINTS];
  logic [STEP_W-1:0] max_step_r;

  logic [DIFF_W-1:0] diff_r;
  logic [POS_W-1:0]  mag_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r;
  logic [MSQ_W-1:0]  msq_r;
  logic              limited_r;
  logic [SUM_W-1:0]  rad_r;
  logic [NORM_W+1:0] rem_r;
  logic [NORM_W-1:0] root_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] dvd_r;
  logic [NORM_W-1:0] drem_r;
  logic [POS_W-1:0]  quo_r;

  logic              out_valid_r;
  logic [JIDX_W-1:0] out_joint_r;
  logic [POS_W-1:0]  out_setpoint_r;
  logic              out_limited_r;
  logic              out_last_r;

  logic [JW-1:0]     idx;
  logic [JW-1:0]     widx;
  logic              wr_ok;
  logic [POS_W-1:0]  t_sel, s_sel, l_sel, u_sel;
  logic [DIFF_W-1:0] diff_c, negd_c;
  logic [MSQ_W-1:0]  msq_c;
  logic [SQ_W-1:0]   sq_c;
  logic [PROD_W-1:0] prod_c;
  logic [NORM_W+3:0] rem_t, trial, rem_sub;
  logic              sq_ge;
  logic [NORM_W:0]   dt, dsub;
  logic              d_ge;
  logic [POS_W-1:0]  qc;
  logic [DIFF_W-1:0] qs, step_c;
  logic [DIFF_W:0]   x_c, ux, lx, xa, xb;

  // select the addressed joint
  assign idx   = cmd.joint[JW-1:0];
  assign widx  = in_joint[JW-1:0];
  assign wr_ok = ({1'b0, in_joint} < (JIDX_W+1)'(JOINTS));
  assign t_sel = target_r[idx];
  assign s_sel = setp_r[idx];
  assign l_sel = lower_r[idx];
  assign u_sel = upper_r[idx];

  // step component and its magnitude
  assign diff_c = {t_sel[POS_W-1], t_sel} - {s_sel[POS_W-1], s_sel};
  assign negd_c = ~diff_c + DIFF_W'(1);

  // products
  assign msq_c  = max_step_r * max_step_r;
  assign sq_c   = mag_r * mag_r;
  assign prod_c = mag_r * max_step_r;

  // one square root step: two radicand bits in, one root bit out
  assign rem_t   = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sq_ge   = (rem_t >= trial);
  assign rem_sub = rem_t - trial;

  // one divider step
  assign dt   = {drem_r, dvd_r[PROD_W-1]};
  assign d_ge = (dt >= {1'b0, root_r});
  assign dsub = dt - {1'b0, root_r};

  // scaled step, advance and clamp (upper first, then lower)
  always_comb begin
    qc     = (quo_r > mag_r) ? mag_r : quo_r;
    qs     = {1'b0, qc};
    step_c = limited_r ? (diff_r[DIFF_W-1] ? (~qs + DIFF_W'(1)) : qs) : diff_r;
    x_c    = {{2{s_sel[POS_W-1]}}, s_sel} + {step_c[DIFF_W-1], step_c};
    ux     = {{2{u_sel[POS_W-1]}}, u_sel};
    lx     = {{2{l_sel[POS_W-1]}}, l_sel};
    xa     = ($signed(x_c) > $signed(ux)) ? ux : x_c;
    xb     = ($signed(xa) < $signed(lx)) ? lx : xa;
  end

  // tables, register and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) begin
        target_r[i] <= '0;
        setp_r[i]   <= '0;
        lower_r[i]  <= {1'b1, {(POS_W-1){1'b0}}};
        upper_r[i]  <= {1'b0, {(POS_W-1){1'b1}}};
      end
      max_step_r  <= MAX_STEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_step_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_WRITE: begin
          if (wr_ok) begin
            case (in_command)
              CMD_SET_TARGET: target_r[widx] <= in_value;
              CMD_SEED: begin
                target_r[widx] <= in_value;
                setp_r[widx]   <= in_value;
              end
              CMD_SET_LOWER:  lower_r[widx] <= in_value;
              CMD_SET_UPPER:  upper_r[widx] <= in_value;
              default: ;
            endcase
          end
        end
        OP_APPLY: begin
          setp_r[idx]  <= xb[POS_W-1:0];
          out_valid_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR: begin
        sum_r <= '0;
        msq_r <= msq_c;
      end
      OP_MAG: begin
        diff_r <= diff_c;
        mag_r  <= diff_c[DIFF_W-1] ? negd_c[POS_W-1:0] : diff_c[POS_W-1:0];
      end
      OP_SQ:  sq_r  <= sq_c;
      OP_ACC: sum_r <= sum_r + SUM_W'(sq_r);
      OP_CMP: begin
        limited_r <= stat.over;
        rad_r     <= sum_r;
        rem_r     <= '0;
        root_r    <= '0;
      end
      OP_SQRT_STEP: begin
        rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
        rem_r  <= sq_ge ? rem_sub[NORM_W+1:0] : rem_t[NORM_W+1:0];
        root_r <= {root_r[NORM_W-2:0], sq_ge};
      end
      OP_PROD: prod_r <= prod_c;
      OP_DIV_INIT: begin
        dvd_r  <= prod_r;
        drem_r <= '0;
        quo_r  <= '0;
      end
      OP_DIV_STEP: begin
        dvd_r  <= {dvd_r[PROD_W-2:0], 1'b0};
        drem_r <= d_ge ? dsub[NORM_W-1:0] : dt[NORM_W-1:0];
        quo_r  <= {quo_r[POS_W-2:0], d_ge};
      end
      OP_APPLY: begin
        out_joint_r    <= cmd.joint;
        out_setpoint_r <= xb[POS_W-1:0];
        out_limited_r  <= limited_r;
        out_last_r     <= (cmd.joint == JIDX_W'(JOINTS - 1));
      end
      default: ;
    endcase
  end

  assign stat.over     = (sum_r > SUM_W'(msq_r));
  assign stat.limited  = limited_r;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_joint    = out_joint_r;
  assign out_setpoint = out_setpoint_r;
  assign out_limited  = out_limited_r;
  assign out_last     = out_last_r;

  // never overwrite a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_APPLY |-> !(out_valid_r && !out_ready))
    else $error("result word overwritten");

  // the scaled step never exceeds the raw step
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_APPLY && limited_r) |-> quo_r <= mag_r)
    else $error("scaled step above raw step");

  // the last-joint flag only marks the final joint
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_joint_r == JIDX_W'(JOINTS - 1))
    else $error("last flag on wrong joint");

endmodule

### rtl/jsrl_ctrl.sv
// Controller: sequences the two joint passes, the root and the divisions of a tick.
module jsrl_ctrl import jsrl_pkg::*; #(
  parameter int JOINTS = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output dp_cmd_t          cmd,
  input  dp_stat_t         stat
);

  ctrl_state_t        state_r, state_nxt;
  logic [JIDX_W-1:0]  joint_r, joint_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic               last_j;

  assign last_j = (joint_r == JIDX_W'(JOINTS - 1));

  // hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      joint_r <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      joint_r <= joint_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    joint_nxt = joint_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_command == CMD_TICK) begin
          state_nxt = ST_MAG1;
          joint_nxt = '0;
        end
      end
      ST_MAG1: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (last_j) begin
          state_nxt = ST_CMP;
          joint_nxt = '0;
        end else begin
          state_nxt = ST_MAG1;
          joint_nxt = joint_r + JIDX_W'(1);
        end
      end
      ST_CMP: begin
        iter_nxt  = '0;
        state_nxt = stat.over ? ST_SQRT : ST_MAG2;
      end
      ST_SQRT: begin
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_MAG2;
        end
      end
      ST_MAG2: state_nxt = stat.limited ? ST_PROD : ST_APPLY;
      ST_PROD: state_nxt = ST_DIVLD;
      ST_DIVLD: begin
        iter_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!stat.out_busy) begin
          if (last_j) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAG2;
            joint_nxt = joint_r + JIDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.joint = joint_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = (in_command == CMD_TICK) ? OP_CLR : OP_WRITE;
        end
      end
      ST_MAG1:  cmd.op = OP_MAG;
      ST_SQ:    cmd.op = OP_SQ;
      ST_ACC:   cmd.op = OP_ACC;
      ST_CMP:   cmd.op = OP_CMP;
      ST_SQRT:  cmd.op = OP_SQRT_STEP;
      ST_MAG2:  cmd.op = OP_MAG;
      ST_PROD:  cmd.op = OP_PROD;
      ST_DIVLD: cmd.op = OP_DIV_INIT;
      ST_DIV:   cmd.op = OP_DIV_STEP;
      ST_APPLY: cmd.op = stat.out_busy ? OP_NONE : OP_APPLY;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // the root is only taken for a step vector above the limit
  a_sqrt_limited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> stat.limited)
    else $error("root taken without limiting");

  // the joint counter stays in range during a tick
  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> joint_r <= JIDX_W'(JOINTS - 1))
    else $error("joint counter out of range");

endmodule
